[rtl/gtrs_pkg.sv]
// Package for the giant tour route splitter: widths, constants, state codes.
// Used by giant_tour_route_split.
`timescale 1ns / 1ps
package gtrs_pkg;
  localparam int MaxClientsDefault = 32;
  localparam int DistBitsDefault   = 20;
  localparam int LoadW  = 21;
  localparam int RCostW = 26;
  localparam int TCostW = 27;
  localparam int IdW    = 6;
  localparam logic [LoadW-1:0]  LoadMax  = {LoadW{1'b1}};
  localparam logic [RCostW-1:0] RCostMax = {RCostW{1'b1}};
  localparam logic [TCostW-1:0] TCostMax = {TCostW{1'b1}};

  typedef enum logic [3:0] {
    ST_LOAD, ST_JRD, ST_IRD, ST_ICALC, ST_JWR,
    ST_BTRD, ST_BTSTEP, ST_EMRD, ST_EMIT, ST_INFEAS
  } state_t;
endpackage

[rtl/gtrs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module gtrs_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

[rtl/giant_tour_route_split.sv]
// Giant tour route splitter: top level with sequencer and memories.
// Depends on gtrs_pkg and gtrs_ram.
`timescale 1ns / 1ps
// Tour positions are taken one per cycle while busy is low; the transfer with
// last_client high starts the split and raises busy. The split is a dynamic
// program on one shared evaluation unit: for each end position j it reads
// entry j, then visits starts 1..j at one per cycle and writes the best
// entry. Tracing back reads each route end's best start and records the end
// at that start, route by route from the last (ST_BTRD, ST_BTSTEP), and a
// read state (ST_EMRD) comes before the first result. Results then stream
// out one per cycle with a strobe (result_valid); the receiver cannot hold
// them off, and busy stays high until the last one is on the ports. An
// over-long tour or a client over capacity gives a single infeasible result.
module giant_tour_route_split
  import gtrs_pkg::*;
#(
  parameter int MAX_CLIENTS = MaxClientsDefault,
  parameter int DIST_BITS   = DistBitsDefault
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic              cfg_we,
  input  logic [LoadW-1:0]  cfg_wdata,
  input  logic [IdW-1:0]    client_id,
  input  logic [15:0]       demand,
  input  logic [DIST_BITS-1:0] depot_to_client,
  input  logic [DIST_BITS-1:0] client_to_depot,
  input  logic [DIST_BITS-1:0] from_previous,
  input  logic              last_client,
  output logic              result_valid,
  output logic [IdW-1:0]    route_client,
  output logic [4:0]        route_number,
  output logic              route_end,
  output logic [LoadW-1:0]  route_load,
  output logic [RCostW-1:0] route_cost,
  output logic [TCostW-1:0] total_cost,
  output logic              feasible,
  output logic              last_result
);
  localparam int Depth = MAX_CLIENTS + 1;
  localparam int PW = $clog2(Depth);   // position 0..MAX_CLIENTS
  localparam logic [PW-1:0] MaxPos = PW'(MAX_CLIENTS);
  localparam logic [PW-1:0] OnePos = PW'(1);

  // Tour entry p (1-based): client, out, back, load and chain prefixes at p
  localparam int TW = IdW + 2 * DIST_BITS + LoadW + RCostW;
  // DP entry: best cost and best start; after the trace back a route start
  // holds its route end in the position field
  localparam int BW = TCostW + PW;
  localparam int SW = ((DIST_BITS > RCostW) ? DIST_BITS : RCostW) + 2;

  state_t state, state_next;
  logic [LoadW-1:0]  capacity;
  logic [PW-1:0]     len;
  logic              ovf;
  logic [LoadW-1:0]  ld_pre;
  logic [RCostW-1:0] ch_pre;

  logic [PW-1:0]     n, j, i;
  logic              found;
  logic [TCostW-1:0] bcost;
  logic [PW-1:0]     bstart;
  logic [TCostW-1:0] tot;
  logic [LoadW-1:0]  base_load;
  logic [LoadW-1:0]  j_load;
  logic [RCostW-1:0] j_chain;
  logic [DIST_BITS-1:0] j_back;
  logic [DIST_BITS-1:0] st_out;
  logic [RCostW-1:0] st_chain;
  logic [PW-1:0]     rend_pos;
  logic              at_start;
  logic [PW-1:0]     rte;

  // Tour memory
  logic           t_we;
  logic [PW-1:0]  t_wa, t_ra;
  logic [TW-1:0]  t_wd, t_rd;
  // DP memory
  logic           b_we;
  logic [PW-1:0]  b_wa, b_ra;
  logic [BW-1:0]  b_wd, b_rd;

  gtrs_ram #(.Width(TW), .Depth(Depth)) u_tour (
    .clk(clk), .we(t_we), .waddr(t_wa), .wdata(t_wd), .raddr(t_ra), .rdata(t_rd));
  gtrs_ram #(.Width(BW), .Depth(Depth)) u_best (
    .clk(clk), .we(b_we), .waddr(b_wa), .wdata(b_wd), .raddr(b_ra), .rdata(b_rd));

  logic [IdW-1:0]       rd_id;
  logic [DIST_BITS-1:0] rd_out, rd_back;
  logic [LoadW-1:0]     rd_load;
  logic [RCostW-1:0]    rd_chain;
  assign {rd_id, rd_out, rd_back, rd_load, rd_chain} = t_rd;
  logic [TCostW-1:0] rd_bcost;
  logic [PW-1:0]     rd_bpos;
  assign {rd_bcost, rd_bpos} = b_rd;

  logic accept, room;
  assign busy   = (state != ST_LOAD);
  assign accept = start && !busy;
  assign room   = (len != MaxPos);

  // Saturating prefix update for the incoming position
  logic [LoadW:0]    ld_sum;
  logic [SW-1:0]     ch_sum;
  logic [LoadW-1:0]  ld_new;
  logic [RCostW-1:0] ch_new;
  logic [PW-1:0]     nlen;
  assign ld_sum = {1'b0, ld_pre} + (LoadW+1)'(demand);
  assign ch_sum = SW'(ch_pre) + SW'(from_previous);
  assign ld_new = ld_sum[LoadW] ? LoadMax : ld_sum[LoadW-1:0];
  assign ch_new = (len == '0) ? '0
                : ((ch_sum > SW'(RCostMax)) ? RCostMax : ch_sum[RCostW-1:0]);
  assign nlen   = len + OnePos;

  // Shared segment cost: out of the first stop, chain between, back of the last
  logic [DIST_BITS-1:0] seg_out, seg_back;
  logic [RCostW-1:0]    seg_hi, seg_lo, seg_chain;
  logic [SW-1:0]        seg_raw;
  logic [RCostW-1:0]    seg_cost;
  always_comb begin
    if (state == ST_EMIT) begin
      seg_out  = at_start ? rd_out : st_out;
      seg_hi   = rd_chain;
      seg_lo   = at_start ? rd_chain : st_chain;
      seg_back = rd_back;
    end else begin
      seg_out  = rd_out;
      seg_hi   = j_chain;
      seg_lo   = rd_chain;
      seg_back = j_back;
    end
  end
  assign seg_chain = seg_hi - seg_lo;
  assign seg_raw   = SW'(seg_out) + SW'(seg_chain) + SW'(seg_back);
  assign seg_cost  = (seg_raw > SW'(RCostMax)) ? RCostMax : seg_raw[RCostW-1:0];

  // Candidate start i for end j; best cost before start 1 is zero
  logic [LoadW-1:0]  seg_load;
  logic [TCostW-1:0] bprev;
  logic [TCostW:0]   val_raw;
  logic [TCostW-1:0] val;
  logic              take;
  assign seg_load = j_load - base_load;
  assign bprev    = (i == OnePos) ? '0 : rd_bcost;
  assign val_raw  = (TCostW+1)'(bprev) + (TCostW+1)'(seg_cost);
  assign val      = val_raw[TCostW] ? TCostMax : val_raw[TCostW-1:0];
  assign take     = (seg_load <= capacity) && (!found || val < bcost);

  // Route bookkeeping at emit time
  logic [PW-1:0]    cur_end;
  logic             closing;
  logic [LoadW-1:0] em_load;
  assign cur_end = at_start ? rd_bpos : rend_pos;
  assign closing = (i == cur_end);
  assign em_load = rd_load - base_load;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD:   if (accept && last_client)
                   state_next = (ovf || !room) ? ST_INFEAS : ST_JRD;
      ST_JRD:    state_next = ST_IRD;
      ST_IRD:    state_next = ST_ICALC;
      ST_ICALC:  if (i == j) state_next = ST_JWR;
      ST_JWR:    state_next = !found ? ST_INFEAS : ((j == n) ? ST_BTRD : ST_JRD);
      ST_BTRD:   state_next = ST_BTSTEP;
      ST_BTSTEP: state_next = (rd_bpos == OnePos) ? ST_EMRD : ST_BTRD;
      ST_EMRD:   state_next = ST_EMIT;
      ST_EMIT:   if (i == n) state_next = ST_LOAD;
      ST_INFEAS: state_next = ST_LOAD;
      default:   state_next = ST_LOAD;
    endcase
  end

  // Memory control
  always_comb begin
    t_we = 1'b0;
    t_wa = nlen;
    t_wd = {client_id, depot_to_client, client_to_depot, ld_new, ch_new};
    t_ra = i;
    b_we = 1'b0;
    b_wa = j;
    b_wd = {bcost, bstart};
    b_ra = i;
    unique case (state)
      ST_LOAD:   t_we = accept && room;
      ST_JRD:    t_ra = j;
      ST_IRD:    b_ra = i - OnePos;
      ST_ICALC:  t_ra = (i == j) ? i : i + OnePos;
      ST_JWR:    b_we = found;
      ST_BTRD:   b_ra = j;
      ST_BTSTEP: begin
        b_we = 1'b1;
        b_wa = rd_bpos;
        b_wd = {{TCostW{1'b0}}, j};
      end
      ST_EMIT: begin
        t_ra = (i == n) ? i : i + OnePos;
        b_ra = (i == n) ? i : i + OnePos;
      end
      default: ;
    endcase
  end

  // Sequencer datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD; capacity <= '0; len <= '0; ovf <= 1'b0;
      ld_pre <= '0; ch_pre <= '0; result_valid <= 1'b0;
    end else begin
      state <= state_next;
      result_valid <= (state == ST_EMIT) || (state == ST_INFEAS);
      if (cfg_we) capacity <= cfg_wdata;
      unique case (state)
        // Store the position, or flag an over-long tour; close on the last one
        ST_LOAD: if (accept) begin
          if (last_client) begin
            n <= room ? nlen : len;
            len <= '0; ld_pre <= '0; ch_pre <= '0; ovf <= 1'b0;
            j <= OnePos;
          end else if (room) begin
            len <= nlen; ld_pre <= ld_new; ch_pre <= ch_new;
          end else begin
            ovf <= 1'b1;
          end
        end
        ST_JRD: begin
          i <= OnePos; found <= 1'b0; bcost <= '0; bstart <= '0;
          base_load <= '0;
        end
        // Hold the end position's data for the whole inner loop
        ST_IRD: begin
          j_load <= rd_load; j_chain <= rd_chain; j_back <= rd_back;
        end
        // Keep the cheapest start; strict compare keeps the earliest on ties
        ST_ICALC: begin
          i <= i + OnePos;
          base_load <= rd_load;
          if (take) begin
            found <= 1'b1; bcost <= val; bstart <= i;
          end
        end
        ST_JWR: begin
          if (j == n) tot <= bcost;
          else j <= j + OnePos;
        end
        // Walk route starts back toward position 1
        ST_BTSTEP: begin
          if (rd_bpos == OnePos) begin
            i <= OnePos; rte <= '0; base_load <= '0; at_start <= 1'b1;
          end else begin
            j <= rd_bpos - OnePos;
          end
        end
        // Emit one client per cycle, closing routes at their recorded ends
        ST_EMIT: begin
          i <= i + OnePos;
          route_client <= rd_id;
          route_number <= 5'(rte);
          route_end    <= closing;
          route_load   <= closing ? em_load : '0;
          route_cost   <= closing ? seg_cost : '0;
          total_cost   <= tot;
          feasible     <= 1'b1;
          last_result  <= (i == n);
          if (at_start) begin
            st_out <= rd_out; st_chain <= rd_chain; rend_pos <= rd_bpos;
          end
          at_start <= closing;
          if (closing) begin
            rte <= rte + OnePos; base_load <= rd_load;
          end
        end
        ST_INFEAS: begin
          route_client <= '0; route_number <= '0; route_end <= 1'b0;
          route_load <= '0; route_cost <= '0; total_cost <= '0;
          feasible <= 1'b0; last_result <= 1'b1;
        end
        default: ;
      endcase
    end
  end
endmodule
